// ----- hw/rtl/tnc_pkg.sv -----
`default_nettype none
package tnc_pkg;

	localparam int NUM_POSITIONS_DEF = 6;
	localparam int POS_POWER_LAST = 6;
	localparam int POS_MIN_SPEED_LAST = 5;

	localparam int MOTION_STOPPED = -2;
	localparam int MOTION_IDLE = -1;
	localparam int MOTION_RESET = 0;

	localparam logic [2:0] FN_TICK = 3'd0;
	localparam logic [2:0] FN_READY = 3'd1;
	localparam logic [2:0] FN_UP = 3'd2;
	localparam logic [2:0] FN_RESET = 3'd3;
	localparam logic [2:0] FN_DOWN = 3'd4;
	localparam logic [2:0] FN_REVERSE = 3'd5;
	localparam logic [2:0] FN_BALANCE = 3'd6;

	localparam logic [1:0] DRV_OFF = 2'd0;
	localparam logic [1:0] DRV_FWD = 2'd1;
	localparam logic [1:0] DRV_BWD = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_NOT_READY = 2'd1;
	localparam logic [1:0] ERR_SLOW = 2'd2;
	localparam logic [1:0] ERR_REVERSE = 2'd3;

	localparam logic [2:0] IND_OFF = 3'd0;
	localparam logic [2:0] IND_IDLE = 3'd1;
	localparam logic [2:0] IND_RESET = 3'd2;
	localparam logic [2:0] IND_PULSE = 3'd3;
	localparam logic [2:0] IND_STEADY = 3'd4;

	localparam logic REG_BALANCE_OFFSET = 1'b0;
	localparam logic REG_STOP_SPEED = 1'b1;

	localparam logic signed [7:0] BALANCE_OFFSET_RST = 8'sd0;
	localparam logic [7:0] STOP_SPEED_RST = 8'd2;

	// x / 100 as (x * 5243) >> 19, exact for x below 43699
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;

	localparam logic [6:0] POS_POWER [0:6] = '{7'd0, 7'd46, 7'd50, 7'd57, 7'd67, 7'd78, 7'd100};
	localparam logic [7:0] POS_MIN_SPEED [0:5] = '{8'd0, 8'd2, 8'd7, 8'd12, 8'd17, 8'd20};

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] speed;
		logic contact_level;
		logic [15:0] hold_count;
		logic signed [7:0] balance_value;
	} req_t;

	typedef struct packed {
		logic signed [3:0] motion_code;
		logic ready_flag;
		logic reverse_flag;
		logic [6:0] left_pct;
		logic [6:0] right_pct;
		logic [1:0] motor_drive;
		logic [1:0] error_code;
		logic [2:0] traction_indication;
	} res_t;

	typedef struct packed {
		logic signed [3:0] motion_code;
		logic ready;
		logic reverse;
		logic [6:0] power;
		logic [6:0] mag;
		logic bal_pos;
		logic [1:0] drive;
		logic [1:0] err;
		logic [2:0] ind;
	} snap_t;

	function automatic logic [6:0] power_of(input int pos);
		logic [2:0] idx;
		begin
			if (pos < 0) idx = 3'd0;
			else if (pos > POS_POWER_LAST) idx = 3'(POS_POWER_LAST);
			else idx = 3'(pos);
			return POS_POWER[idx];
		end
	endfunction

	function automatic logic [7:0] min_speed_of(input int pos);
		logic [2:0] idx;
		begin
			if (pos < 0) idx = 3'd0;
			else if (pos > POS_MIN_SPEED_LAST) idx = 3'(POS_MIN_SPEED_LAST);
			else idx = 3'(pos);
			return POS_MIN_SPEED[idx];
		end
	endfunction

	function automatic logic signed [7:0] sat100(input logic signed [8:0] v);
		begin
			if (v > 9'sd100) return 8'sd100;
			else if (v < -9'sd100) return -8'sd100;
			else return 8'(v);
		end
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tnc_state.sv -----
`default_nettype none
module tnc_state #(
	parameter int NUM_POSITIONS = tnc_pkg::NUM_POSITIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic upd,
	input wire logic en,
	input wire tnc_pkg::req_t req_s1,
	input wire logic signed [7:0] balance_offset,
	input wire logic [7:0] stop_speed,
	output tnc_pkg::snap_t snap_s2
);

	localparam int MW = $clog2(NUM_POSITIONS + 1) + 1;
	localparam logic signed [MW-1:0] M_STOP = MW'(tnc_pkg::MOTION_STOPPED);
	localparam logic signed [MW-1:0] M_IDLE = MW'(tnc_pkg::MOTION_IDLE);
	localparam logic signed [MW-1:0] M_RESET = MW'(tnc_pkg::MOTION_RESET);
	localparam logic signed [MW-1:0] M_ONE = MW'(1);
	localparam logic signed [MW-1:0] M_TOP = MW'(NUM_POSITIONS);

	logic signed [MW-1:0] motion_q, nxt_motion;
	logic ready_q, nxt_ready;
	logic reverse_q, nxt_reverse;
	logic [6:0] power_q, nxt_power;
	logic signed [7:0] balance_q, nxt_balance;
	logic [1:0] drive_q, nxt_drive;
	logic [1:0] err;
	logic signed [8:0] eff;
	logic signed [7:0] b;
	logic signed [7:0] b_neg;
	logic [2:0] ind;

	always_comb begin
		nxt_motion = motion_q;
		nxt_ready = ready_q;
		nxt_reverse = reverse_q;
		nxt_power = power_q;
		nxt_balance = balance_q;
		nxt_drive = drive_q;
		err = tnc_pkg::ERR_NONE;
		unique case (req_s1.func)
			tnc_pkg::FN_TICK: begin
				if (nxt_motion == M_RESET && req_s1.speed == stop_speed) begin
					nxt_drive = tnc_pkg::DRV_OFF;
					nxt_motion = M_STOP;
				end
				if (nxt_motion == M_STOP && req_s1.speed > stop_speed)
					nxt_motion = M_IDLE;
				if (nxt_motion == M_IDLE && req_s1.speed <= stop_speed)
					nxt_motion = M_STOP;
			end
			tnc_pkg::FN_READY: begin
				nxt_ready = ~req_s1.contact_level;
				if (req_s1.contact_level && motion_q >= M_ONE) begin
					nxt_motion = M_RESET;
					nxt_power = tnc_pkg::power_of(tnc_pkg::MOTION_RESET);
				end
			end
			tnc_pkg::FN_UP: begin
				if (!ready_q)
					err = tnc_pkg::ERR_NOT_READY;
				else if (motion_q >= M_ONE && motion_q < M_TOP &&
						req_s1.speed < tnc_pkg::min_speed_of(int'(motion_q)))
					err = tnc_pkg::ERR_SLOW;
				else if (motion_q <= M_IDLE) begin
					nxt_drive = reverse_q ? tnc_pkg::DRV_BWD : tnc_pkg::DRV_FWD;
					nxt_motion = M_ONE;
					nxt_power = tnc_pkg::power_of(1);
				end else if (motion_q < M_TOP) begin
					nxt_motion = motion_q + M_ONE;
					nxt_power = tnc_pkg::power_of(int'(motion_q) + 1);
				end else begin
					nxt_power = tnc_pkg::power_of(int'(motion_q));
				end
			end
			tnc_pkg::FN_RESET: begin
				if (!ready_q)
					err = tnc_pkg::ERR_NOT_READY;
				else if (motion_q >= M_ONE) begin
					nxt_motion = M_RESET;
					nxt_power = tnc_pkg::power_of(tnc_pkg::MOTION_RESET);
				end
			end
			tnc_pkg::FN_DOWN: begin
				if (!ready_q)
					err = tnc_pkg::ERR_NOT_READY;
				else if (motion_q >= M_ONE) begin
					nxt_motion = motion_q - M_ONE;
					nxt_power = tnc_pkg::power_of(int'(motion_q) - 1);
				end
			end
			tnc_pkg::FN_REVERSE: begin
				if (!ready_q)
					err = tnc_pkg::ERR_NOT_READY;
				else if (req_s1.hold_count <= 16'd1) begin
					if (motion_q > M_STOP)
						err = tnc_pkg::ERR_REVERSE;
					else
						nxt_reverse = ~reverse_q;
				end
			end
			tnc_pkg::FN_BALANCE: begin
				nxt_balance = tnc_pkg::sat100(9'(req_s1.balance_value));
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		eff = 9'(nxt_balance) - 9'(balance_offset);
		b = tnc_pkg::sat100(eff);
		b_neg = -b;
		if (nxt_motion == M_STOP) ind = tnc_pkg::IND_OFF;
		else if (nxt_motion == M_IDLE) ind = tnc_pkg::IND_IDLE;
		else if (nxt_motion == M_RESET) ind = tnc_pkg::IND_RESET;
		else if (nxt_motion < M_TOP) ind = tnc_pkg::IND_PULSE;
		else ind = tnc_pkg::IND_STEADY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= M_STOP;
			ready_q <= 1'b0;
			reverse_q <= 1'b0;
			power_q <= '0;
			balance_q <= '0;
			drive_q <= tnc_pkg::DRV_OFF;
		end else if (upd) begin
			motion_q <= nxt_motion;
			ready_q <= nxt_ready;
			reverse_q <= nxt_reverse;
			power_q <= nxt_power;
			balance_q <= nxt_balance;
			drive_q <= nxt_drive;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snap_s2.motion_code <= 4'(nxt_motion);
			snap_s2.ready <= nxt_ready;
			snap_s2.reverse <= nxt_reverse;
			snap_s2.power <= nxt_power;
			snap_s2.mag <= b[7] ? b_neg[6:0] : b[6:0];
			snap_s2.bal_pos <= ~b[7] && (b != 8'sd0);
			snap_s2.drive <= nxt_drive;
			snap_s2.err <= err;
			snap_s2.ind <= ind;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tnc_split.sv -----
`default_nettype none
module tnc_split (
	input wire logic clk,
	input wire logic en,
	input wire tnc_pkg::snap_t snap_s2,
	output tnc_pkg::res_t res
);

	tnc_pkg::snap_t snap_s3;
	logic [13:0] prod_s3;
	logic [26:0] scaled;
	logic [6:0] cut;
	logic [6:0] reduced;

	// mag * power <= 10000
	always_ff @(posedge clk) begin
		if (en) begin
			snap_s3 <= snap_s2;
			prod_s3 <= 14'(snap_s2.mag) * 14'(snap_s2.power);
		end
	end

	always_comb begin
		scaled = 27'(prod_s3) * 27'(tnc_pkg::DIV100_MUL);
		cut = scaled[tnc_pkg::DIV100_SHIFT +: 7];
		reduced = snap_s3.power - cut;
		res.motion_code = snap_s3.motion_code;
		res.ready_flag = snap_s3.ready;
		res.reverse_flag = snap_s3.reverse;
		res.left_pct = snap_s3.bal_pos ? reduced : snap_s3.power;
		res.right_pct = snap_s3.bal_pos ? snap_s3.power : reduced;
		res.motor_drive = snap_s3.drive;
		res.error_code = snap_s3.err;
		res.traction_indication = snap_s3.ind;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/traction_notch_controller_unit.sv -----
// channel   | handshake              | payload
// request   | req_valid / req_stall  | req   (tnc_pkg::req_t)
// result    | res_valid / res_stall  | res   (tnc_pkg::res_t)
// config    | cfg_we                 | cfg_addr, cfg_wdata
//
// One request per cycle while no result is stalled; the accepting edge
// loads the input register, then the state update, the product and the
// result register load in turn. arst_n clears the valid bits, the traction
// state and the configuration registers. A stalled result freezes the whole
// pipe; req_stall is res_stall while a result is waiting.
`default_nettype none
module traction_notch_controller_unit #(
	parameter int NUM_POSITIONS = tnc_pkg::NUM_POSITIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire tnc_pkg::req_t req,
	output logic res_valid,
	input wire logic res_stall,
	output tnc_pkg::res_t res,
	input wire logic cfg_we,
	input wire logic cfg_addr,
	input wire logic [7:0] cfg_wdata
);

	logic adv;
	logic v_s1_q, v_s2_q, v_s3_q;
	tnc_pkg::req_t req_s1;
	tnc_pkg::snap_t snap_s2;
	tnc_pkg::res_t res_nxt;
	logic signed [7:0] balance_offset_q;
	logic [7:0] stop_speed_q;

	assign adv = !(res_valid && res_stall);
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_offset_q <= tnc_pkg::BALANCE_OFFSET_RST;
			stop_speed_q <= tnc_pkg::STOP_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tnc_pkg::REG_BALANCE_OFFSET: balance_offset_q <= cfg_wdata;
				tnc_pkg::REG_STOP_SPEED: stop_speed_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s1_q <= req_valid;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			res_valid <= v_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
			res <= res_nxt;
		end
	end

	tnc_state #(
		.NUM_POSITIONS(NUM_POSITIONS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.upd(v_s1_q && adv),
		.en(adv),
		.req_s1(req_s1),
		.balance_offset(balance_offset_q),
		.stop_speed(stop_speed_q),
		.snap_s2(snap_s2)
	);

	tnc_split u_split (
		.clk(clk),
		.en(adv),
		.snap_s2(snap_s2),
		.res(res_nxt)
	);

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> v_s1_q)
		else $error("accepted request not captured");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(v_s3_q))
		else $error("result without request in flight");

	a_no_power_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.traction_indication == tnc_pkg::IND_OFF ||
			res.traction_indication == tnc_pkg::IND_IDLE ||
			res.traction_indication == tnc_pkg::IND_RESET))
		|-> (res.left_pct == 7'd0 && res.right_pct == 7'd0))
		else $error("power while not at a position");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.left_pct <= 7'd100 && res.right_pct <= 7'd100))
		else $error("motor power out of range");

endmodule
`default_nettype wire

// ----- verif/traction_notch_controller_unit_test.sv -----
`default_nettype none
module traction_notch_controller_unit_test;
	import tnc_pkg::*;

	localparam int NOTCHES = NUM_POSITIONS_DEF;
	localparam logic [2:0] FN_SPARE = 3'd7;
	localparam int PER_SETTING = 315;
	localparam int NUM_SETTINGS = 6;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 8;
	localparam int IDLE_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic cfg_addr = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	traction_notch_controller_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// traction model
	int notch_power_tbl[7] = '{0, 46, 50, 57, 67, 78, 100};
	int notch_speed_tbl[6] = '{0, 2, 7, 12, 17, 20};
	int m_motion = MOTION_STOPPED;
	logic m_ready = 1'b0;
	logic m_reverse = 1'b0;
	int m_power = 0;
	int m_balance = 0;
	logic [1:0] m_drive = DRV_OFF;
	int m_boff = 0;
	int m_stop = 2;

	req_t notch_cmds[$];
	res_t predicted_status[$];
	int n_queued = 0;
	int n_requests = 0;
	int n_checked = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm_mode = 1'b0;
	int long_req = 0;
	int long_served = 0;
	int long_left = 0;
	int hold_left = 0;
	int gap_left = 0;
	bit offering;

	function automatic int clip100(int v);
		if (v > 100) return 100;
		if (v < -100) return -100;
		return v;
	endfunction

	function automatic void move_to(int pos);
		int idx;
		idx = pos < 0 ? 0 : (pos > 6 ? 6 : pos);
		m_motion = pos;
		m_power = notch_power_tbl[idx];
	endfunction

	function automatic res_t step_traction(req_t r);
		res_t o;
		int b;
		int mag;
		int pl;
		int pr;
		int sidx;
		logic [1:0] err;
		err = ERR_NONE;
		case (r.func)
			FN_TICK: begin
				if (m_motion == MOTION_RESET && int'(r.speed) == m_stop) begin
					m_drive = DRV_OFF;
					m_motion = MOTION_STOPPED;
				end
				if (m_motion == MOTION_STOPPED && int'(r.speed) > m_stop)
					m_motion = MOTION_IDLE;
				if (m_motion == MOTION_IDLE && int'(r.speed) <= m_stop)
					m_motion = MOTION_STOPPED;
			end
			FN_READY: begin
				m_ready = ~r.contact_level;
				if (!m_ready && m_motion >= 1)
					move_to(MOTION_RESET);
			end
			FN_UP, FN_RESET, FN_DOWN, FN_REVERSE: begin
				sidx = m_motion < 0 ? 0 : (m_motion > 5 ? 5 : m_motion);
				if (!m_ready)
					err = ERR_NOT_READY;
				else if (r.func == FN_UP) begin
					if (m_motion >= 1 && m_motion < NOTCHES &&
							int'(r.speed) < notch_speed_tbl[sidx])
						err = ERR_SLOW;
					else if (m_motion <= MOTION_IDLE) begin
						m_drive = m_reverse ? DRV_BWD : DRV_FWD;
						move_to(1);
					end else
						move_to(m_motion < NOTCHES ? m_motion + 1 : NOTCHES);
				end else if (r.func == FN_RESET) begin
					if (m_motion >= 1)
						move_to(MOTION_RESET);
				end else if (r.func == FN_DOWN) begin
					if (m_motion >= 1)
						move_to(m_motion - 1);
				end else if (r.hold_count <= 16'd1) begin
					if (m_motion > MOTION_STOPPED)
						err = ERR_REVERSE;
					else
						m_reverse = ~m_reverse;
				end
			end
			FN_BALANCE: m_balance = clip100(int'(r.balance_value));
			default: ;
		endcase

		b = clip100(m_balance - m_boff);
		mag = b < 0 ? -b : b;
		pl = m_power;
		pr = m_power;
		if (b > 0)
			pl = m_power - (mag * m_power) / 100;
		else
			pr = m_power - (mag * m_power) / 100;

		o.motion_code = m_motion[3:0];
		o.ready_flag = m_ready;
		o.reverse_flag = m_reverse;
		o.left_pct = pl[6:0];
		o.right_pct = pr[6:0];
		o.motor_drive = m_drive;
		o.error_code = err;
		if (m_motion == MOTION_STOPPED)
			o.traction_indication = IND_OFF;
		else if (m_motion == MOTION_IDLE)
			o.traction_indication = IND_IDLE;
		else if (m_motion == MOTION_RESET)
			o.traction_indication = IND_RESET;
		else if (m_motion < NOTCHES)
			o.traction_indication = IND_PULSE;
		else
			o.traction_indication = IND_STEADY;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch on %s: got %0d, expected %0d (result %0d)",
			what, got, want, n_checked);
	endtask

	task automatic check_status(res_t got);
		res_t want;
		if (predicted_status.size() == 0) begin
			report_mismatch("unexpected result", 1, 0);
			return;
		end
		want = predicted_status.pop_front();
		n_checked++;
		if (got.motion_code !== want.motion_code)
			report_mismatch("motion_code", int'(got.motion_code), int'(want.motion_code));
		if (got.ready_flag !== want.ready_flag)
			report_mismatch("ready_flag", int'(got.ready_flag), int'(want.ready_flag));
		if (got.reverse_flag !== want.reverse_flag)
			report_mismatch("reverse_flag", int'(got.reverse_flag),
				int'(want.reverse_flag));
		if (got.left_pct !== want.left_pct)
			report_mismatch("left_pct", int'(got.left_pct), int'(want.left_pct));
		if (got.right_pct !== want.right_pct)
			report_mismatch("right_pct", int'(got.right_pct), int'(want.right_pct));
		if (got.motor_drive !== want.motor_drive)
			report_mismatch("motor_drive", int'(got.motor_drive), int'(want.motor_drive));
		if (got.error_code !== want.error_code)
			report_mismatch("error_code", int'(got.error_code), int'(want.error_code));
		if (got.traction_indication !== want.traction_indication)
			report_mismatch("traction_indication", int'(got.traction_indication),
				int'(want.traction_indication));
	endtask

	function automatic int draw_wait();
		return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predicted_status.push_back(step_traction(req));
				n_requests++;
				offering = 1'b0;
			end else
				offering = req_valid;
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (notch_cmds.size() != 0) begin
					req <= notch_cmds.pop_front();
					req_valid <= 1'b1;
					gap_left = calm_mode ? 0 : draw_wait();
				end else
					req_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				check_status(res);
				hold_left = calm_mode ? 0 : draw_wait();
			end
			if (long_req != long_served) begin
				long_served = long_req;
				long_left = LONG_HOLD;
			end
			if (long_left > 0) begin
				long_left--;
				res_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else
				res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("FAIL traction_notch_controller_unit");
			$finish;
		end
	end

	function automatic req_t mk(logic [2:0] fn, int spd, bit contact, int hold, int bval);
		req_t r;
		r.func = fn;
		r.speed = spd[7:0];
		r.contact_level = contact;
		r.hold_count = hold[15:0];
		r.balance_value = bval[7:0];
		return r;
	endfunction

	function automatic req_t rand_item();
		req_t r;
		int pick;
		int s;
		r.func = FN_TICK;
		r.speed = 8'($urandom_range(0, 255));
		r.contact_level = 1'($urandom_range(0, 1));
		r.hold_count = 16'($urandom_range(0, 65535));
		r.balance_value = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			case ($urandom_range(0, 3))
				0: s = m_stop;
				1: s = m_stop < 255 ? m_stop + 1 : 255;
				2: s = m_stop > 0 ? m_stop - 1 : 0;
				default: s = int'(r.speed);
			endcase
			r.speed = s[7:0];
		end else if (pick < 26) begin
			r.func = FN_READY;
			r.contact_level = ($urandom_range(0, 5) == 0);
		end else if (pick < 55) begin
			r.func = FN_UP;
			if ($urandom_range(0, 3) == 0)
				r.speed = 8'($urandom_range(0, 25));
		end else if (pick < 62)
			r.func = FN_RESET;
		else if (pick < 75)
			r.func = FN_DOWN;
		else if (pick < 85) begin
			r.func = FN_REVERSE;
			if ($urandom_range(0, 2) != 0)
				r.hold_count = 16'($urandom_range(0, 1));
		end else if (pick < 97)
			r.func = FN_BALANCE;
		else
			r.func = FN_SPARE;
		return r;
	endfunction

	task automatic queue_cmd(req_t r);
		notch_cmds.push_back(r);
		n_queued++;
	endtask

	task automatic write_reg(logic addr, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_BALANCE_OFFSET)
			m_boff = int'($signed(val));
		else
			m_stop = int'(val);
	endtask

	task automatic drain_pipe();
		while (n_checked != n_queued)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	int boff_set[NUM_SETTINGS] = '{-100, 100, 0, 37, -64, 0};
	int stop_set[NUM_SETTINGS] = '{0, 255, 2, 5, 20, 2};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_cmd(mk(FN_UP, 30, 0, 0, 0));
		queue_cmd(mk(FN_REVERSE, 0, 0, 0, 0));
		queue_cmd(mk(FN_READY, 0, 0, 0, 0));
		queue_cmd(mk(FN_REVERSE, 0, 0, 1, 0));
		queue_cmd(mk(FN_REVERSE, 0, 0, 65535, 0));
		queue_cmd(mk(FN_TICK, 3, 0, 0, 0));
		queue_cmd(mk(FN_REVERSE, 0, 0, 0, 0));
		queue_cmd(mk(FN_UP, 0, 0, 0, 0));
		queue_cmd(mk(FN_UP, 1, 0, 0, 0));
		queue_cmd(mk(FN_UP, 255, 0, 0, 0));
		queue_cmd(mk(FN_UP, 7, 0, 0, 0));
		queue_cmd(mk(FN_UP, 12, 0, 0, 0));
		queue_cmd(mk(FN_UP, 17, 0, 0, 0));
		queue_cmd(mk(FN_UP, 20, 0, 0, 0));
		queue_cmd(mk(FN_UP, 0, 0, 0, 0));
		queue_cmd(mk(FN_BALANCE, 0, 0, 0, 127));
		queue_cmd(mk(FN_BALANCE, 0, 0, 0, -128));
		queue_cmd(mk(FN_BALANCE, 0, 0, 0, 0));
		queue_cmd(mk(FN_DOWN, 0, 0, 0, 0));
		queue_cmd(mk(FN_RESET, 0, 0, 0, 0));
		queue_cmd(mk(FN_DOWN, 0, 0, 0, 0));
		queue_cmd(mk(FN_UP, 0, 0, 0, 0));
		queue_cmd(mk(FN_READY, 255, 1, 65535, -1));
		queue_cmd(mk(FN_TICK, 2, 0, 0, 0));
		queue_cmd(mk(FN_SPARE, 0, 0, 0, 0));
		drain_pipe();

		boff_set[NUM_SETTINGS - 1] = $urandom_range(0, 200) - 100;
		stop_set[NUM_SETTINGS - 1] = $urandom_range(0, 255);
		for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
			write_reg(REG_BALANCE_OFFSET, boff_set[ph][7:0]);
			write_reg(REG_STOP_SPEED, stop_set[ph][7:0]);
			calm_mode = (ph == 2);
			// hold results back while requests keep coming
			if (ph == 3)
				long_req++;
			for (int i = 0; i < PER_SETTING; i++)
				queue_cmd(rand_item());
			drain_pipe();
		end

		$display("checked %0d results against %0d requests over %0d register settings",
			n_checked, n_requests, NUM_SETTINGS + 1);
		$display("included a %0d-cycle result hold-off and a gap-free phase", LONG_HOLD);
		if (mismatches == 0 && predicted_status.size() == 0)
			$display("PASS traction_notch_controller_unit");
		else
			$display("FAIL traction_notch_controller_unit");
		$finish;
	end

endmodule
`default_nettype wire
